// File: hdl/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, token codes and keyword table for the script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int LINE_BITS     = 24;
    localparam int COLUMN_BITS   = 16;
    localparam int OFFSET_BITS   = 32;
    localparam int KEYWORD_CHARS = 9;
    localparam int WLEN_BITS     = $clog2(KEYWORD_CHARS + 2);
    localparam int KW_COUNT      = 14;

    typedef enum logic [5:0] {
        TOK_NUMBER       = 6'd0,
        TOK_STRING       = 6'd1,
        TOK_IDENTIFIER   = 6'd2,
        TOK_BOOLEAN      = 6'd3,
        TOK_NULL         = 6'd4,
        TOK_UNDEFINED    = 6'd5,
        TOK_LET          = 6'd6,
        TOK_CONST        = 6'd7,
        TOK_VAR          = 6'd8,
        TOK_FUNCTION     = 6'd9,
        TOK_RETURN       = 6'd10,
        TOK_IF           = 6'd11,
        TOK_ELSE         = 6'd12,
        TOK_FOR          = 6'd13,
        TOK_WHILE        = 6'd14,
        TOK_CLASS        = 6'd15,
        TOK_PLUS         = 6'd16,
        TOK_MINUS        = 6'd17,
        TOK_MULTIPLY     = 6'd18,
        TOK_DIVIDE       = 6'd19,
        TOK_MODULO       = 6'd20,
        TOK_ASSIGN       = 6'd21,
        TOK_EQUALS       = 6'd22,
        TOK_NOT_EQUALS   = 6'd23,
        TOK_LESS_THAN    = 6'd24,
        TOK_GREATER_THAN = 6'd25,
        TOK_LPAREN       = 6'd26,
        TOK_RPAREN       = 6'd27,
        TOK_LBRACE       = 6'd28,
        TOK_RBRACE       = 6'd29,
        TOK_LBRACKET     = 6'd30,
        TOK_RBRACKET     = 6'd31,
        TOK_SEMICOLON    = 6'd32,
        TOK_COMMA        = 6'd33,
        TOK_DOT          = 6'd34,
        TOK_NEWLINE      = 6'd35,
        TOK_INVALID      = 6'd36,
        TOK_END          = 6'd37
    } stl_tok_t;

    typedef enum logic [6:0] {
        MODE_IDLE = 7'b0000001,
        MODE_NUM  = 7'b0000010,
        MODE_STR  = 7'b0000100,
        MODE_ESC  = 7'b0001000,
        MODE_WORD = 7'b0010000,
        MODE_EQ   = 7'b0100000,
        MODE_BANG = 7'b1000000
    } stl_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_source;
    } stl_in_t;

    typedef struct packed {
        logic                   record_is_token;
        logic [7:0]             value_byte;
        logic [5:0]             token_type;
        logic [LINE_BITS-1:0]   start_line;
        logic [COLUMN_BITS-1:0] start_column;
        logic [OFFSET_BITS-1:0] start_position;
        logic                   last_of_item;
    } stl_out_t;

    typedef logic [KEYWORD_CHARS-1:0][7:0] stl_word_t;

    // keyword text right-aligned, first char in the highest used byte
    localparam logic [KEYWORD_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
        "let", "const", "var", "function", "return", "if", "else", "for",
        "while", "class", "true", "false", "null", "undefined"
    };
    localparam int KW_LEN [KW_COUNT] = '{3, 5, 3, 8, 6, 2, 4, 3, 5, 5, 4, 5, 4, 9};
    localparam stl_tok_t KW_TYPE [KW_COUNT] = '{
        TOK_LET, TOK_CONST, TOK_VAR, TOK_FUNCTION, TOK_RETURN, TOK_IF, TOK_ELSE,
        TOK_FOR, TOK_WHILE, TOK_CLASS, TOK_BOOLEAN, TOK_BOOLEAN, TOK_NULL,
        TOK_UNDEFINED
    };

    function automatic stl_tok_t kw_type(stl_word_t w, logic [WLEN_BITS-1:0] len);
        stl_tok_t t;
        logic     hit;
        t = TOK_IDENTIFIER;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (int'(len) == KW_LEN[k]);
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
                if (i < KW_LEN[k]) begin
                    if (w[i] != KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit) begin
                t = KW_TYPE[k];
            end
        end
        return t;
    endfunction

endpackage

// File: hdl/stl_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_out_queue
// Two-entry result buffer; takes all results of one item at once and
// hands them out one per transaction.
// ----------------------------------------------------------------------------
module stl_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [1:0]       push_count,
    input  stl_pkg::stl_out_t push_first,
    input  stl_pkg::stl_out_t push_second,
    output logic             free,
    output logic             valid,
    input  logic             stall,
    output stl_pkg::stl_out_t head
);
    import stl_pkg::*;

    logic [1:0] cnt_reg;
    stl_out_t   q0_reg;
    stl_out_t   q1_reg;
    logic       pop;

    assign valid = (cnt_reg != 2'd0);
    assign head  = q0_reg;
    assign pop   = valid && !stall;
    assign free  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (push)
        begin
            cnt_reg <= push_count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q0_reg <= push_first;
            q1_reg <= push_second;
        end
        else if (pop)
        begin
            q0_reg <= q1_reg;
        end
    end

endmodule

// File: hdl/script_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_token_lexer
// Streaming lexer: one source byte in, value bytes and token records out.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while the output buffer has room, else
// src_stall holds it. Each byte is lexed in the cycle it is accepted and
// gives zero, one or two results, which land in a two-entry output buffer.
// A byte that gives two results (it closes a pending token and starts
// another) holds the input while the second result drains. Keyword matching
// compares the held word against a constant table when the word closes.
module script_token_lexer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  stl_pkg::stl_in_t  src_item,
    output logic              tok_valid,
    input  logic              tok_stall,
    output stl_pkg::stl_out_t tok_item
);
    import stl_pkg::*;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;

    stl_mode_t              mode_reg, mode_next;
    logic                   quote_reg, quote_next;
    stl_word_t              word_reg, word_next;
    logic [WLEN_BITS-1:0]   wlen_reg, wlen_next;
    logic [LINE_BITS-1:0]   tline_reg, tline_next, line_reg, line_next;
    logic [COLUMN_BITS-1:0] tcol_reg, tcol_next, col_reg, col_next;
    logic [OFFSET_BITS-1:0] toff_reg, toff_next, off_reg, off_next;
    logic                   blank_reg, blank_next;

    logic       accept, free;
    logic       have_a, have_b, do_idle, do_adv;
    stl_out_t   rec_a, rec_b, first, second;
    logic [1:0] count;
    logic [7:0] c;

    function automatic stl_out_t mk(logic is_tok, logic [7:0] v, stl_tok_t t,
                                    logic [LINE_BITS-1:0] l, logic [COLUMN_BITS-1:0] cl,
                                    logic [OFFSET_BITS-1:0] o);
        stl_out_t r;
        r.record_is_token = is_tok;
        r.value_byte      = v;
        r.token_type      = t;
        r.start_line      = l;
        r.start_column    = cl;
        r.start_position  = o;
        r.last_of_item    = 1'b0;
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] x);
        return (x >= "0") && (x <= "9");
    endfunction

    function automatic logic word_start(logic [7:0] x);
        return ((x >= "a") && (x <= "z")) || ((x >= "A") && (x <= "Z")) ||
               (x == "_") || (x == "$");
    endfunction

    assign c         = src_item.ch;
    assign accept    = src_valid && free;
    assign src_stall = !free;

    always_comb
    begin
        stl_out_t close_rec;
        stl_tok_t t;
        mode_next  = mode_reg;
        quote_next = quote_reg;
        word_next  = word_reg;
        wlen_next  = wlen_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        toff_next  = toff_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        off_next   = off_reg;
        blank_next = blank_reg;
        have_a     = 1'b0;
        have_b     = 1'b0;
        rec_a      = '0;
        rec_b      = '0;
        do_idle    = 1'b0;
        do_adv     = 1'b0;
        t          = TOK_INVALID;

        // record of the pending token when a byte closes it
        close_rec = mk(1'b1, 8'd0, TOK_STRING, tline_reg, tcol_reg, toff_reg);
        case (mode_reg)
            MODE_NUM:  close_rec.token_type = TOK_NUMBER;
            MODE_WORD: close_rec.token_type = kw_type(word_reg, wlen_reg);
            MODE_EQ:   close_rec.token_type = TOK_ASSIGN;
            MODE_BANG:
            begin
                close_rec.token_type = TOK_INVALID;
                close_rec.value_byte = "!";
            end
            default:   close_rec.token_type = TOK_STRING;
        endcase

        if (src_item.end_of_source)
        begin
            if (mode_reg != MODE_IDLE)
            begin
                have_a = 1'b1;
                rec_a  = close_rec;
            end
            else if (blank_reg)
            begin
                have_a = 1'b1;
                rec_a  = mk(1'b1, 8'd0, TOK_END, line_reg, col_reg, off_reg);
            end
            mode_next  = MODE_IDLE;
            quote_next = 1'b0;
            wlen_next  = '0;
            tline_next = LINE_BITS'(1);
            tcol_next  = COLUMN_BITS'(1);
            toff_next  = '0;
            line_next  = LINE_BITS'(1);
            col_next   = COLUMN_BITS'(1);
            off_next   = '0;
            blank_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_STR:
                begin
                    do_adv = 1'b1;
                    if (c == (quote_reg ? 8'h27 : 8'h22))
                    begin
                        have_a    = 1'b1;
                        rec_a     = mk(1'b1, 8'd0, TOK_STRING, tline_reg, tcol_reg, toff_reg);
                        mode_next = MODE_IDLE;
                    end
                    else if (c == 8'h5c)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        have_a = 1'b1;
                        rec_a  = mk(1'b0, c, TOK_STRING, tline_reg, tcol_reg, toff_reg);
                    end
                end
                MODE_ESC:
                begin
                    do_adv    = 1'b1;
                    have_a    = 1'b1;
                    mode_next = MODE_STR;
                    rec_a     = mk(1'b0, c, TOK_STRING, tline_reg, tcol_reg, toff_reg);
                    case (c)
                        "n":     rec_a.value_byte = 8'h0a;
                        "t":     rec_a.value_byte = 8'h09;
                        "r":     rec_a.value_byte = 8'h0d;
                        default: rec_a.value_byte = c;
                    endcase
                end
                MODE_NUM:
                begin
                    have_a = 1'b1;
                    if (is_digit(c) || (c == "."))
                    begin
                        do_adv = 1'b1;
                        rec_a  = mk(1'b0, c, TOK_NUMBER, tline_reg, tcol_reg, toff_reg);
                    end
                    else
                    begin
                        rec_a   = close_rec;
                        do_idle = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    have_a = 1'b1;
                    if (word_start(c) || is_digit(c))
                    begin
                        do_adv = 1'b1;
                        rec_a  = mk(1'b0, c, TOK_IDENTIFIER, tline_reg, tcol_reg, toff_reg);
                        if (wlen_reg < WLEN_BITS'(KEYWORD_CHARS))
                        begin
                            word_next[wlen_reg] = c;
                            wlen_next = wlen_reg + WLEN_BITS'(1);
                        end
                        else
                        begin
                            wlen_next = WLEN_BITS'(KEYWORD_CHARS + 1);
                        end
                    end
                    else
                    begin
                        rec_a   = close_rec;
                        do_idle = 1'b1;
                    end
                end
                MODE_EQ, MODE_BANG:
                begin
                    have_a = 1'b1;
                    if (c == "=")
                    begin
                        do_adv    = 1'b1;
                        mode_next = MODE_IDLE;
                        rec_a     = mk(1'b1, 8'd0,
                                       (mode_reg == MODE_EQ) ? TOK_EQUALS : TOK_NOT_EQUALS,
                                       tline_reg, tcol_reg, toff_reg);
                    end
                    else
                    begin
                        rec_a   = close_rec;
                        do_idle = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            if (do_idle)
            begin
                do_adv    = 1'b1;
                mode_next = MODE_IDLE;
                if (c inside {8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d})
                begin
                    blank_next = 1'b1;
                end
                else
                begin
                    blank_next = 1'b0;
                    tline_next = line_reg;
                    tcol_next  = col_reg;
                    toff_next  = off_reg;
                    if (is_digit(c))
                    begin
                        mode_next = MODE_NUM;
                        have_b    = 1'b1;
                        rec_b     = mk(1'b0, c, TOK_NUMBER, line_reg, col_reg, off_reg);
                    end
                    else if ((c == 8'h22) || (c == 8'h27))
                    begin
                        mode_next  = MODE_STR;
                        quote_next = (c == 8'h27);
                    end
                    else if (word_start(c))
                    begin
                        mode_next    = MODE_WORD;
                        word_next[0] = c;
                        wlen_next    = WLEN_BITS'(1);
                        have_b       = 1'b1;
                        rec_b        = mk(1'b0, c, TOK_IDENTIFIER, line_reg, col_reg, off_reg);
                    end
                    else if (c == "=")
                    begin
                        mode_next = MODE_EQ;
                    end
                    else if (c == "!")
                    begin
                        mode_next = MODE_BANG;
                    end
                    else
                    begin
                        case (c)
                            "+":     t = TOK_PLUS;
                            "-":     t = TOK_MINUS;
                            "*":     t = TOK_MULTIPLY;
                            "/":     t = TOK_DIVIDE;
                            "%":     t = TOK_MODULO;
                            "<":     t = TOK_LESS_THAN;
                            ">":     t = TOK_GREATER_THAN;
                            "(":     t = TOK_LPAREN;
                            ")":     t = TOK_RPAREN;
                            "{":     t = TOK_LBRACE;
                            "}":     t = TOK_RBRACE;
                            "[":     t = TOK_LBRACKET;
                            "]":     t = TOK_RBRACKET;
                            ";":     t = TOK_SEMICOLON;
                            ",":     t = TOK_COMMA;
                            ".":     t = TOK_DOT;
                            8'h0a:   t = TOK_NEWLINE;
                            default: t = TOK_INVALID;
                        endcase
                        have_b = 1'b1;
                        rec_b  = mk(1'b1, (t == TOK_INVALID) ? c : 8'd0, t,
                                    line_reg, col_reg, off_reg);
                    end
                end
            end

            // saturating position counters
            if (do_adv)
            begin
                if (c == 8'h0a)
                begin
                    if (line_reg != LINE_MAX)
                    begin
                        line_next = line_reg + LINE_BITS'(1);
                    end
                    col_next = COLUMN_BITS'(1);
                end
                else if (col_reg != COL_MAX)
                begin
                    col_next = col_reg + COLUMN_BITS'(1);
                end
                if (off_reg != OFF_MAX)
                begin
                    off_next = off_reg + OFFSET_BITS'(1);
                end
            end
        end

        first  = have_a ? rec_a : rec_b;
        second = rec_b;
        count  = {1'b0, have_a} + {1'b0, have_b};
        if (count == 2'd2)
        begin
            second.last_of_item = 1'b1;
        end
        else
        begin
            first.last_of_item = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            quote_reg <= 1'b0;
            wlen_reg  <= '0;
            tline_reg <= LINE_BITS'(1);
            tcol_reg  <= COLUMN_BITS'(1);
            toff_reg  <= '0;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= COLUMN_BITS'(1);
            off_reg   <= '0;
            blank_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            wlen_reg  <= wlen_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            toff_reg  <= toff_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            off_reg   <= off_next;
            blank_reg <= blank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

    stl_out_queue u_out_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (accept),
        .push_count  (count),
        .push_first  (first),
        .push_second (second),
        .free        (free),
        .valid       (tok_valid),
        .stall       (tok_stall),
        .head        (tok_item)
    );

endmodule
